### hw/rtl/size_class_free_list_allocator_unit_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property on clk, off while rst_n is low.
`define SCFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication on clk, off while rst_n is low.
`define SCFL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SCFL_ASSERT(lbl, prop, msg)
`define SCFL_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/scfl_pkg.sv
`default_nettype none
package scfl_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_STORE_BYTES    = 1048576;
  localparam int unsigned DEF_PAGE_BYTES     = 4096;
  localparam int unsigned DEF_MIN_CLASS_LOG2 = 4;
  localparam int unsigned DEF_MAX_CLASS_LOG2 = 16;

  // Fixed field widths.
  localparam int unsigned REQ_W    = 18;
  localparam int unsigned OFF_W    = 20;
  localparam int unsigned HEAD_W   = 21;
  localparam int unsigned FREE_W   = 22;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ALU_W    = 32;

  localparam logic [HEAD_W-1:0] EMPTY_MARK = {HEAD_W{1'b1}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Request to the shared adder.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage
`default_nettype wire

### hw/rtl/scfl_alu.sv
`default_nettype none
module scfl_alu (
  input  scfl_pkg::alu_req_t          req,
  output logic [scfl_pkg::ALU_W-1:0]  sum
);
  import scfl_pkg::*;

  // a + b, or a - b as a + ~b + 1
  assign sum = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);

endmodule
`default_nettype wire

### hw/rtl/scfl_link_mem.sv
`default_nettype none
module scfl_link_mem #(
  parameter int unsigned IDX_W = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_addr,
  input  logic [scfl_pkg::HEAD_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              rd_addr,
  output logic [scfl_pkg::HEAD_W-1:0]   rd_data
);
  import scfl_pkg::*;

  localparam int unsigned DEPTH = 1 << IDX_W;

  logic [HEAD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/size_class_free_list_allocator_unit.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | in_operation, in_request_bytes, in_chunk_offset
// out     | output    | out_valid/out_ready | out_granted_offset, out_status, out_free_bytes
//
// Steps: accept, check and result for a free or an error; accept, check, pop and
//   result for an allocate from a non-empty class. An allocate from an empty class
//   adds a step to credit the region, a carve that writes its links one at a time,
//   since the link memory has a single write port and all address steps share one
//   adder, and a read of the link of the new head.
// Reset: synchronous active-low rst_n; class heads go empty, store top to one page,
//   free count to zero. The link memory is not cleared.
// Stalls: an item is accepted while a previous result sits in the output register;
//   the new result waits in the final state until the output register frees up.
`default_nettype none
`include "size_class_free_list_allocator_unit_macros.svh"
module size_class_free_list_allocator_unit #(
  parameter int unsigned STORE_BYTES    = scfl_pkg::DEF_STORE_BYTES,
  parameter int unsigned PAGE_BYTES     = scfl_pkg::DEF_PAGE_BYTES,
  parameter int unsigned MIN_CLASS_LOG2 = scfl_pkg::DEF_MIN_CLASS_LOG2,
  parameter int unsigned MAX_CLASS_LOG2 = scfl_pkg::DEF_MAX_CLASS_LOG2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [scfl_pkg::REQ_W-1:0]          in_request_bytes,
  input  logic [scfl_pkg::OFF_W-1:0]          in_chunk_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scfl_pkg::OFF_W-1:0]          out_granted_offset,
  output logic [scfl_pkg::STATUS_W-1:0]       out_status,
  output logic signed [scfl_pkg::FREE_W-1:0]  out_free_bytes
);
  import scfl_pkg::*;

  // Store and page sizes must be powers of two; the block itself does not enforce it.
  localparam int unsigned NUM_CLASSES = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int unsigned CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned TOP_W = $clog2(STORE_BYTES) + 1;
  localparam int unsigned IDX_W = $clog2(STORE_BYTES) - MIN_CLASS_LOG2;
  localparam int unsigned SZ_W  = MAX_CLASS_LOG2 + 1;
  localparam int unsigned PG_W  = $clog2(PAGE_BYTES) + 1;
  localparam int unsigned RG_W  = (SZ_W > PG_W) ? SZ_W : PG_W;
  localparam int unsigned LG_W  = $clog2(REQ_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_GROW, S_CARVE, S_RD, S_POP, S_DONE
  } state_t;

  state_t              state_r;
  logic                op_r;
  logic                over_r;
  logic [CLS_W-1:0]    cls_r;
  logic [OFF_W-1:0]    off_r;
  logic [HEAD_W-1:0]   heads_r [NUM_CLASSES];
  logic [TOP_W-1:0]    top_r;
  logic [TOP_W-1:0]    here_r;
  logic [FREE_W-1:0]   free_r;
  logic [OFF_W-1:0]    gnt_r;
  logic [STATUS_W-1:0] st_r;
  logic                out_valid_r;
  logic [OFF_W-1:0]    out_gnt_r;
  logic [STATUS_W-1:0] out_st_r;
  logic [FREE_W-1:0]   out_free_r;

  // Request decode: class = ceil(log2(req)) - MIN, floored at zero.
  logic [REQ_W-1:0] req_m1;
  logic [LG_W-1:0]  lg;
  logic [LG_W-1:0]  cls_full;
  logic             over_in;

  assign req_m1 = in_request_bytes - REQ_W'(1);

  always_comb begin
    lg = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (req_m1[i]) lg = LG_W'(i + 1);
    end
    if (in_request_bytes <= REQ_W'(1)) lg = '0;
  end

  assign cls_full = (lg > LG_W'(MIN_CLASS_LOG2)) ? lg - LG_W'(MIN_CLASS_LOG2) : '0;
  assign over_in  = cls_full >= LG_W'(NUM_CLASSES);

  // Per-class sizes
  logic [HEAD_W-1:0] head_cur;
  logic [SZ_W-1:0]   csize;
  logic [RG_W-1:0]   region;

  assign head_cur = over_r ? EMPTY_MARK : heads_r[cls_r];
  assign csize    = SZ_W'(1) << (32'(cls_r) + 32'(MIN_CLASS_LOG2));
  assign region   = (RG_W'(csize) >= RG_W'(PAGE_BYTES)) ? RG_W'(csize) : RG_W'(PAGE_BYTES);

  // Shared adder: top+region, free+region, free+/-csize, here+csize
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_sum;

  always_comb begin
    alu_req = '{a: ALU_W'(free_r), b: ALU_W'(csize), sub: 1'b0};
    unique case (state_r)
      S_CHECK: begin
        if (op_r == OP_ALLOC) alu_req = '{a: ALU_W'(top_r), b: ALU_W'(region), sub: 1'b0};
      end
      S_GROW:  alu_req = '{a: ALU_W'(free_r), b: ALU_W'(region), sub: 1'b0};
      S_CARVE: alu_req = '{a: ALU_W'(here_r), b: ALU_W'(csize), sub: 1'b0};
      S_POP:   alu_req = '{a: ALU_W'(free_r), b: ALU_W'(csize), sub: 1'b1};
      default: alu_req = '{a: ALU_W'(free_r), b: ALU_W'(csize), sub: 1'b0};
    endcase
  end

  scfl_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  function automatic logic [IDX_W-1:0] link_idx(input logic [ALU_W-1:0] v);
    return v[MIN_CLASS_LOG2 +: IDX_W];
  endfunction

  // Link memory ports
  logic              carve_last;
  logic              full;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [HEAD_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [HEAD_W-1:0] mem_rd_data;

  assign carve_last = alu_sum[TOP_W-1:0] == top_r;
  assign full       = alu_sum > ALU_W'(STORE_BYTES);

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = link_idx(ALU_W'(here_r));
    mem_wr_data = carve_last ? EMPTY_MARK : HEAD_W'(alu_sum);
    if (state_r == S_CARVE) begin
      mem_wr_en = 1'b1;
    end else if (state_r == S_CHECK && !over_r && op_r == OP_FREE) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = link_idx(ALU_W'(off_r));
      mem_wr_data = head_cur;
    end
  end

  assign mem_rd_en = (state_r == S_RD) ||
                     (state_r == S_CHECK && !over_r && op_r == OP_ALLOC &&
                      head_cur != EMPTY_MARK);

  scfl_link_mem #(.IDX_W(IDX_W)) u_links (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (link_idx(ALU_W'(head_cur))),
    .rd_data (mem_rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int c = 0; c < NUM_CLASSES; c++) heads_r[c] <= EMPTY_MARK;
      top_r       <= TOP_W'(PAGE_BYTES);
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; the final state reloads the register itself
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            over_r  <= over_in;
            cls_r   <= over_in ? '0 : CLS_W'(cls_full);
            off_r   <= in_chunk_offset;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          gnt_r <= '0;
          st_r  <= ST_OK;
          if (over_r) begin
            st_r    <= ST_OVERSIZE;
            state_r <= S_DONE;
          end else if (op_r == OP_FREE) begin
            heads_r[cls_r] <= HEAD_W'(off_r);
            free_r         <= FREE_W'(alu_sum);
            state_r        <= S_DONE;
          end else if (head_cur != EMPTY_MARK) begin
            state_r <= S_POP;
          end else if (full) begin
            st_r    <= ST_FULL;
            state_r <= S_DONE;
          end else begin
            // carve a fresh region at the old top
            heads_r[cls_r] <= HEAD_W'(ALU_W'(top_r));
            here_r         <= top_r;
            top_r          <= alu_sum[TOP_W-1:0];
            state_r        <= S_GROW;
          end
        end
        S_GROW: begin
          free_r  <= FREE_W'(alu_sum);
          state_r <= S_CARVE;
        end
        S_CARVE: begin
          here_r <= alu_sum[TOP_W-1:0];
          if (carve_last) state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_POP;
        end
        S_POP: begin
          gnt_r          <= OFF_W'(head_cur);
          heads_r[cls_r] <= mem_rd_data;
          free_r         <= FREE_W'(alu_sum);
          state_r        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_gnt_r   <= gnt_r;
            out_st_r    <= st_r;
            out_free_r  <= free_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready           = state_r == S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_granted_offset = out_gnt_r;
  assign out_status         = out_st_r;
  assign out_free_bytes     = signed'(out_free_r);

  `SCFL_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_r == S_CHECK), "accept did not start check")
  `SCFL_ASSERT(a_top_stable_carve, (state_r == S_CARVE) |=> $stable(top_r), "store top moved while carving")
  `SCFL_ASSERT_IMPL(a_wr_states, mem_wr_en, (state_r == S_CARVE || state_r == S_CHECK), "link write outside check or carve")
  `SCFL_ASSERT_IMPL(a_err_zero_grant, (out_valid_r && out_st_r != ST_OK), (out_gnt_r == '0), "error result with nonzero offset")
  `SCFL_ASSERT(a_pop_after_read, (state_r == S_POP) |-> ($past(mem_rd_en)), "pop without link read")

endmodule
`default_nettype wire

### sim/size_class_free_list_allocator_unit_tb.sv
`timescale 1ns / 1ps

module size_class_free_list_allocator_unit_tb;
  import scfl_pkg::*;

  // Geometry of the block as built (default parameters).
  localparam int unsigned STORE_SZ   = DEF_STORE_BYTES;
  localparam int unsigned PAGE_SZ    = DEF_PAGE_BYTES;
  localparam int unsigned MIN_LG     = DEF_MIN_CLASS_LOG2;
  localparam int unsigned MAX_LG     = DEF_MAX_CLASS_LOG2;
  localparam int unsigned NUM_CLS    = MAX_LG - MIN_LG + 1;
  localparam int unsigned LINK_SLOTS = STORE_SZ >> MIN_LG;
  localparam int unsigned BIGGEST    = 32'd1 << MAX_LG;

  localparam int unsigned RANDOM_ITEMS = 860;
  localparam int unsigned QUIET_ITEMS  = 120;  // tail of the run with no idling
  localparam int unsigned DRAIN_CYCLES = 300;  // margin after the longest carve

  // One result item as the block should produce it.
  typedef struct packed {
    logic [OFF_W-1:0]    granted;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_bytes;
  } grant_t;

  // A chunk the stimulus currently owns, so it can be handed back well-formed.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [REQ_W-1:0] bytes;
  } chunk_t;

  // Free-list predictor plus the queue of results still owed by the block.
  class free_list_model;
    logic [HEAD_W-1:0] heads[NUM_CLS];
    logic [HEAD_W-1:0] links[LINK_SLOTS];
    int unsigned       store_top;
    logic [FREE_W-1:0] free_total;
    grant_t            owed[$];
    int unsigned       errors;

    function new();
      foreach (heads[c]) heads[c] = EMPTY_MARK;
      foreach (links[i]) links[i] = '0;
      store_top  = PAGE_SZ;  // first page is the header
      free_total = '0;
      errors     = 0;
    endfunction

    function int unsigned link_slot(input logic [31:0] offset);
      return (offset >> MIN_LG) % LINK_SLOTS;
    endfunction

    // Apply one accepted item to the free lists; queue and return its result.
    function grant_t note_request(input logic op, input logic [REQ_W-1:0] req,
                                  input logic [OFF_W-1:0] offset);
      grant_t            g;
      int unsigned       lg;
      int unsigned       cls;
      int unsigned       csize;
      int unsigned       region;
      int unsigned       here;
      logic [HEAD_W-1:0] head;
      g  = '0;
      lg = 0;
      while (lg < 20 && (32'd1 << lg) < req) lg++;
      cls = (lg > MIN_LG) ? lg - MIN_LG : 0;
      if (cls >= NUM_CLS) begin
        g.status = ST_OVERSIZE;
      end else begin
        csize = 32'd1 << (cls + MIN_LG);
        if (op == OP_FREE) begin
          // push, no sanity check on the offset
          links[link_slot(offset)] = heads[cls];
          heads[cls] = {1'b0, offset};
          free_total = free_total + 22'(csize);
        end else begin
          g.status = ST_OK;
          if (heads[cls] == EMPTY_MARK) begin
            region = ((csize + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
            if (store_top + region > STORE_SZ) begin
              g.status = ST_FULL;
            end else begin
              // carve the new region into a list in address order
              for (int unsigned i = 0; i < region; i += csize) begin
                here = store_top + i;
                links[link_slot(here)] = (i + csize < region) ? 21'(here + csize) : EMPTY_MARK;
              end
              heads[cls] = 21'(store_top);
              store_top += region;
              free_total = free_total + 22'(region);
            end
          end
          if (g.status == ST_OK) begin
            head       = heads[cls];
            g.granted  = head[OFF_W-1:0];
            heads[cls] = links[link_slot(head)];
            free_total = free_total - 22'(csize);
          end
        end
      end
      g.free_bytes = free_total;
      owed.push_back(g);
      return g;
    endfunction

    function void check_grant(input logic [OFF_W-1:0] granted,
                              input logic [STATUS_W-1:0] status,
                              input logic [FREE_W-1:0] free_bytes);
      grant_t g;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed: granted %h status %0d free %h",
                 $time, granted, status, free_bytes);
        errors++;
        return;
      end
      g = owed.pop_front();
      if (granted !== g.granted) begin
        $display("%0t: granted_offset expected %h actual %h", $time, g.granted, granted);
        errors++;
      end
      if (status !== g.status) begin
        $display("%0t: status expected %0d actual %0d", $time, g.status, status);
        errors++;
      end
      if (free_bytes !== g.free_bytes) begin
        $display("%0t: free_bytes expected %h actual %h", $time, g.free_bytes, free_bytes);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_operation;
  logic [REQ_W-1:0]           in_request_bytes;
  logic [OFF_W-1:0]           in_chunk_offset;
  logic                       out_valid;
  logic                       out_ready;
  logic [OFF_W-1:0]           out_granted_offset;
  logic [STATUS_W-1:0]        out_status;
  logic signed [FREE_W-1:0]   out_free_bytes;

  free_list_model model = new();
  chunk_t         owned[$];     // chunks handed out and not yet returned
  logic           quiet_tail;   // set for the last stretch: no idling on either side
  int unsigned    gap_odds;     // 1 in gap_odds items is preceded by an idle burst

  size_class_free_list_allocator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_request_bytes   (in_request_bytes),
    .in_chunk_offset    (in_chunk_offset),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted_offset (out_granted_offset),
    .out_status         (out_status),
    .out_free_bytes     (out_free_bytes)
  );

  always #5 clk = ~clk;

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("size_class_free_list_allocator_unit verification failed");
    $finish;
  end

  // Result side: every accepted result goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      model.check_grant(out_granted_offset, out_status, out_free_bytes);
    end
  end

  // Result-side backpressure: ready stretches broken by stall bursts.
  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Drive one item and hold it until the handshake; valid is left high so the
  // next item can follow back to back. Called at a rising edge.
  task automatic send_item(input logic op, input logic [REQ_W-1:0] req,
                           input logic [OFF_W-1:0] offset);
    grant_t g;
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_request_bytes <= req;
    in_chunk_offset  <= offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = model.note_request(op, req, offset);
    if (op == OP_ALLOC && g.status == ST_OK) owned.push_back('{g.granted, req});
  endtask

  // Sender-side idle burst, sometimes.
  task automatic maybe_pause();
    if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Hand back a random owned chunk with the size it was requested with.
  task automatic return_owned();
    int unsigned k;
    chunk_t      ch;
    k  = $urandom_range(0, owned.size() - 1);
    ch = owned[k];
    owned.delete(k);
    send_item(OP_FREE, ch.bytes, ch.offset);
  endtask

  // Request size: mostly small classes, some large, a few oversize.
  function automatic logic [REQ_W-1:0] pick_bytes();
    int unsigned lg;
    lg = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 17) : $urandom_range(0, 8);
    if (lg == 0) return REQ_W'($urandom_range(0, 1));
    if (lg == 17) return REQ_W'($urandom_range(BIGGEST + 1, 2 * BIGGEST));
    return REQ_W'($urandom_range((32'd1 << (lg - 1)) + 1, 32'd1 << lg));
  endfunction

  initial begin
    int unsigned pick;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_operation     <= OP_ALLOC;
    in_request_bytes <= '0;
    in_chunk_offset  <= '0;
    quiet_tail       = 1'b0;
    gap_odds         = 4;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero request, class edges, largest class, oversize both ways,
    // well-formed returns, bogus offsets pushed and then popped again.
    send_item(OP_ALLOC, REQ_W'(0), '0);            // zero request lands in class 0
    send_item(OP_ALLOC, REQ_W'(1), '0);
    send_item(OP_ALLOC, REQ_W'(16), '0);
    send_item(OP_ALLOC, REQ_W'(17), '0);           // first request of class 1
    send_item(OP_ALLOC, REQ_W'(4096), '0);         // chunk equals the page
    maybe_pause();
    send_item(OP_ALLOC, REQ_W'(4097), '0);         // region wider than a page
    send_item(OP_ALLOC, REQ_W'(BIGGEST), '0);      // largest class
    send_item(OP_ALLOC, REQ_W'(BIGGEST + 1), '0);  // just above largest class
    send_item(OP_ALLOC, REQ_W'(2 * BIGGEST), '0);  // twice the largest class
    send_item(OP_FREE, REQ_W'(2 * BIGGEST), '1);   // oversize free changes nothing
    return_owned();
    return_owned();
    maybe_pause();
    send_item(OP_FREE, REQ_W'(0), '1);             // bogus offset, all ones
    send_item(OP_ALLOC, REQ_W'(0), '0);            // hands the bogus chunk back
    send_item(OP_FREE, REQ_W'(32), '0);            // bogus offset zero
    send_item(OP_ALLOC, REQ_W'(32), '0);
    send_item(OP_ALLOC, REQ_W'(32), '0);
    send_item(OP_FREE, REQ_W'(BIGGEST), 20'h12340);
    send_item(OP_ALLOC, REQ_W'(BIGGEST), '0);

    // Random: alloc/free traffic with the owned-chunk list driving well-formed
    // returns, plus noise frees at random offsets and sizes.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 8;
          default: gap_odds = 2;
        endcase
      end
      quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);

      // Two-thirds in: run the store into the full condition with
      // largest-class allocations, then flood the largest list with bogus
      // frees so the free count overflows the signed range of out_free_bytes.
      if (n == (2 * RANDOM_ITEMS) / 3) begin
        for (int unsigned f = 0; f < 20; f++) begin
          maybe_pause();
          send_item(OP_ALLOC, REQ_W'(BIGGEST), '0);
        end
        for (int unsigned f = 0; f < 40; f++) begin
          maybe_pause();
          send_item(OP_FREE, REQ_W'(BIGGEST), OFF_W'($urandom()));
        end
      end

      maybe_pause();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(OP_ALLOC, pick_bytes(), OFF_W'($urandom()));
      end else if (pick < 93 && owned.size() != 0) begin
        return_owned();
      end else begin
        send_item(OP_FREE, pick_bytes(), OFF_W'($urandom()));
      end
    end

    in_valid <= 1'b0;
    while (model.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (model.errors == 0 && model.owed.size() == 0) begin
      $display("size_class_free_list_allocator_unit verification clean");
    end else begin
      $display("size_class_free_list_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
